@@ hdl/sotq_pkg.sv @@
// Shared types and constants for the speed-ordered turn queue.
package sotq_pkg;

  localparam int KEY_W  = 8;
  localparam int TAG_W  = 8;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd1;
  localparam logic [OP_W-1:0] OP_ROTATE  = 3'd2;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] new_key;
    logic [TAG_W-1:0] new_tag;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  head_tag;
    logic [KEY_W-1:0]  head_key;
    logic              head_valid;
    logic [OCC_W-1:0]  occupancy;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_PLACE,
    S_WLINK,
    S_WKEY,
    S_FIN1,
    S_FIN2,
    S_ROT2,
    S_DQ2,
    S_LOADH,
    S_RESP
  } state_t;

endpackage

@@ hdl/sotq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sotq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/speed_ordered_turn_queue.sv @@
// Speed-ordered turn queue: linked list of up to DEPTH entries kept in two RAMs.
//
// Entries (key, tag) live in a data RAM and are chained head to tail through a
// link RAM; both have registered reads. One item is in work at a time and
// each item gives one result transfer. Clear, full-queue inserts, dequeue of
// an empty queue, rotate of fewer than two entries and unused opcodes go
// straight to the result state; enqueue passes through S_PLACE, rotate
// through S_ROT2 and S_LOADH, and dequeue through S_DQ2, then S_LOADH unless
// it empties the queue. Insert by key needs only S_PLACE if it lands at the
// head or tail; else it walks the list, one list step a cycle, with link and
// data reads of the next entry issued together, and links in through S_FIN1
// and, mid-list, S_FIN2. Taking a freed slot off the free chain adds S_ALLOC
// to an insert or enqueue. The list walk sets the longest item time.
// Freed slots are chained through the link RAM; untouched slots are handed
// out by a fill counter, so no clearing pass is needed after reset or clear.
// A new transfer is taken while a finished result still waits on out_stall;
// the next result then waits in its last state until the output frees up.
module speed_ordered_turn_queue #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sotq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sotq_pkg::out_t out_data
);
  import sotq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = KEY_W + TAG_W;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [PW-1:0]     slot_r, slot_nxt;
  logic [PW-1:0]     cur_r, cur_nxt;
  logic [PW-1:0]     nxt_r, nxt_nxt;
  logic [CW-1:0]     steps_r, steps_nxt;
  logic [PW-1:0]     head_r, head_nxt;
  logic [PW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     fresh_r, fresh_nxt;
  logic [PW-1:0]     fhead_r, fhead_nxt;
  logic [KEY_W-1:0]  hkey_r, hkey_nxt;
  logic [TAG_W-1:0]  htag_r, htag_nxt;
  logic [KEY_W-1:0]  tkey_r, tkey_nxt;
  logic [KEY_W-1:0]  dkey_r, dkey_nxt;
  logic [TAG_W-1:0]  dtag_r, dtag_nxt;
  logic              deq_r, deq_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic          dm_we;
  logic [PW-1:0] dm_waddr, dm_raddr;
  logic [DW-1:0] dm_wdata, dm_rdata;
  logic          lk_we;
  logic [PW-1:0] lk_waddr, lk_raddr, lk_wdata, lk_rdata;

  logic [KEY_W-1:0] rd_key;
  logic [TAG_W-1:0] rd_tag;
  logic             in_xfer;
  logic             res_valid;

  assign rd_key = dm_rdata[DW-1:TAG_W];
  assign rd_tag = dm_rdata[TAG_W-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign res_valid = deq_r || (cnt_r != '0);

  sotq_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  sotq_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    tag_r    <= tag_nxt;
    slot_r   <= slot_nxt;
    cur_r    <= cur_nxt;
    nxt_r    <= nxt_nxt;
    steps_r  <= steps_nxt;
    fhead_r  <= fhead_nxt;
    hkey_r   <= hkey_nxt;
    htag_r   <= htag_nxt;
    tkey_r   <= tkey_nxt;
    dkey_r   <= dkey_nxt;
    dtag_r   <= dtag_nxt;
    deq_r    <= deq_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    tag_nxt       = tag_r;
    slot_nxt      = slot_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    steps_nxt     = steps_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    fresh_nxt     = fresh_r;
    fhead_nxt     = fhead_r;
    hkey_nxt      = hkey_r;
    htag_nxt      = htag_r;
    tkey_nxt      = tkey_r;
    dkey_nxt      = dkey_r;
    dtag_nxt      = dtag_r;
    deq_nxt       = deq_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    dm_we    = 1'b0;
    dm_waddr = slot_r;
    dm_wdata = {key_r, tag_r};
    dm_raddr = nxt_r;
    lk_we    = 1'b0;
    lk_waddr = slot_r;
    lk_wdata = slot_r;
    lk_raddr = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt     = in_data.opcode;
          key_nxt    = in_data.new_key;
          tag_nxt    = in_data.new_tag;
          deq_nxt    = 1'b0;
          status_nxt = ST_DONE;
          state_nxt  = S_RESP;
          case (in_data.opcode)
            OP_INSERT, OP_ENQUEUE: begin
              if (cnt_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else if (fresh_r < CW'(DEPTH)) begin
                slot_nxt  = PW'(fresh_r);
                fresh_nxt = fresh_r + CW'(1);
                state_nxt = S_PLACE;
              end else begin
                // reuse a freed slot: pop the free chain
                lk_raddr  = fhead_r;
                slot_nxt  = fhead_r;
                state_nxt = S_ALLOC;
              end
            end
            OP_ROTATE: begin
              if (cnt_r >= CW'(2)) begin
                lk_raddr  = head_r;
                lk_we     = 1'b1;
                lk_waddr  = tail_r;
                lk_wdata  = head_r;
                tail_nxt  = head_r;
                tkey_nxt  = hkey_r;
                state_nxt = S_ROT2;
              end
            end
            OP_DEQUEUE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                deq_nxt   = 1'b1;
                dkey_nxt  = hkey_r;
                dtag_nxt  = htag_r;
                slot_nxt  = head_r;
                lk_raddr  = head_r;
                cnt_nxt   = cnt_r - CW'(1);
                state_nxt = S_DQ2;
              end
            end
            OP_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              cnt_nxt   = '0;
              fresh_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_ALLOC: begin
        fhead_nxt = lk_rdata;
        state_nxt = S_PLACE;
      end

      S_PLACE: begin
        dm_we     = 1'b1;
        state_nxt = S_RESP;
        if (cnt_r == '0) begin
          head_nxt = slot_r;
          tail_nxt = slot_r;
          hkey_nxt = key_r;
          htag_nxt = tag_r;
          tkey_nxt = key_r;
          cnt_nxt  = cnt_r + CW'(1);
        end else if (op_r == OP_ENQUEUE || key_r < tkey_r) begin
          lk_we    = 1'b1;
          lk_waddr = tail_r;
          lk_wdata = slot_r;
          tail_nxt = slot_r;
          tkey_nxt = key_r;
          cnt_nxt  = cnt_r + CW'(1);
          // new head when it outranks the head (insert only)
          if (op_r != OP_ENQUEUE && hkey_r < key_r) begin
            lk_waddr = slot_r;
            lk_wdata = head_r;
            tail_nxt = tail_r;
            tkey_nxt = tkey_r;
            head_nxt = slot_r;
            hkey_nxt = key_r;
            htag_nxt = tag_r;
          end
        end else if (hkey_r < key_r) begin
          lk_we    = 1'b1;
          lk_waddr = slot_r;
          lk_wdata = head_r;
          head_nxt = slot_r;
          hkey_nxt = key_r;
          htag_nxt = tag_r;
          cnt_nxt  = cnt_r + CW'(1);
        end else begin
          cur_nxt   = head_r;
          steps_nxt = '0;
          if (cnt_r > CW'(1)) begin
            lk_raddr  = head_r;
            state_nxt = S_WLINK;
          end else begin
            state_nxt = S_FIN1;
          end
        end
      end

      S_WLINK: begin
        nxt_nxt   = lk_rdata;
        dm_raddr  = lk_rdata;
        lk_raddr  = lk_rdata;
        state_nxt = S_WKEY;
      end

      S_WKEY: begin
        // read data holds key and link of the entry after cur
        state_nxt = S_FIN1;
        if (rd_key >= key_r) begin
          cur_nxt   = nxt_r;
          steps_nxt = steps_r + CW'(1);
          if ((steps_nxt + CW'(1)) < cnt_r) begin
            nxt_nxt   = lk_rdata;
            dm_raddr  = lk_rdata;
            lk_raddr  = lk_rdata;
            state_nxt = S_WKEY;
          end
        end
      end

      S_FIN1: begin
        lk_we = 1'b1;
        if (cur_r == tail_r) begin
          lk_waddr  = cur_r;
          lk_wdata  = slot_r;
          tail_nxt  = slot_r;
          tkey_nxt  = key_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_RESP;
        end else begin
          lk_waddr  = slot_r;
          lk_wdata  = nxt_r;
          state_nxt = S_FIN2;
        end
      end

      S_FIN2: begin
        lk_we     = 1'b1;
        lk_waddr  = cur_r;
        lk_wdata  = slot_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_RESP;
      end

      S_ROT2: begin
        head_nxt  = lk_rdata;
        dm_raddr  = lk_rdata;
        state_nxt = S_LOADH;
      end

      S_DQ2: begin
        // push the old head on the free chain
        lk_we     = 1'b1;
        lk_waddr  = slot_r;
        lk_wdata  = fhead_r;
        fhead_nxt = slot_r;
        if (cnt_r == '0) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          state_nxt = S_RESP;
        end else begin
          head_nxt  = lk_rdata;
          dm_raddr  = lk_rdata;
          state_nxt = S_LOADH;
        end
      end

      S_LOADH: begin
        hkey_nxt  = rd_key;
        htag_nxt  = rd_tag;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        // hold here while the previous result still waits on out_stall
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt      = 1'b1;
          out_nxt.status     = status_r;
          out_nxt.head_valid = res_valid;
          out_nxt.occupancy  = OCC_W'(cnt_r);
          if (deq_r) begin
            out_nxt.head_key = dkey_r;
            out_nxt.head_tag = dtag_r;
          end else if (res_valid) begin
            out_nxt.head_key = hkey_r;
            out_nxt.head_tag = htag_r;
          end else begin
            out_nxt.head_key = '0;
            out_nxt.head_tag = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
